@@ hdl/cpbs_pkg.sv @@
`default_nettype none

package cpbs_pkg;

  localparam int unsigned DATA_W          = 64;
  localparam int unsigned MASK_W          = 8;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned BITS_PER_RESULT_DEF = 8;

  typedef enum logic [2:0] {
    CFG_SCAN_KIND,
    CFG_ELEMENT_WIDTH,
    CFG_COMPARE_OP,
    CFG_RANGE_MODE,
    CFG_SCAN_VALUE
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_VALUE,
    KIND_COLUMN,
    KIND_RANGE
  } scan_kind_e;

  typedef enum logic [1:0] {
    EW_8,
    EW_16,
    EW_32,
    EW_64
  } elem_width_e;

  typedef enum logic [2:0] {
    OP_EQ,
    OP_GE,
    OP_GT,
    OP_LE,
    OP_LT,
    OP_NEQ
  } cmp_op_e;

  typedef enum logic [1:0] {
    RNG_INC_INC,
    RNG_INC_EXC,
    RNG_EXC_INC,
    RNG_EXC_EXC
  } rng_mode_e;

  typedef struct packed {
    logic [1:0]        scan_kind;
    logic [1:0]        element_width;
    logic [2:0]        compare_op;
    logic [1:0]        range_mode;
    logic [DATA_W-1:0] scan_value;
  } cfg_t;

  // sign-extend the low bits of a column value to the full width
  function automatic logic signed [DATA_W-1:0] sext(input logic [DATA_W-1:0] v,
                                                    input logic [1:0] w);
    logic signed [DATA_W-1:0] r;
    r = $signed(v);
    unique case (w)
      EW_8:    r = $signed({{(DATA_W-8){v[7]}}, v[7:0]});
      EW_16:   r = $signed({{(DATA_W-16){v[15]}}, v[15:0]});
      EW_32:   r = $signed({{(DATA_W-32){v[31]}}, v[31:0]});
      EW_64:   r = $signed(v);
      default: r = $signed(v);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/cpbs_if.sv @@
`default_nettype none

interface cpbs_in_if import cpbs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element;
  logic signed [DATA_W-1:0] other_operand;
  logic signed [DATA_W-1:0] upper_bound;
  logic                     end_of_scan;

  modport source (output valid, element, other_operand, upper_bound, end_of_scan,
                  input ready);
  modport sink (input valid, element, other_operand, upper_bound, end_of_scan,
                output ready);
endinterface

interface cpbs_out_if import cpbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] mask_byte;
  logic              last_byte;

  modport source (output valid, mask_byte, last_byte, input ready);
  modport sink (input valid, mask_byte, last_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/cpbs_pred.sv @@
`default_nettype none

module cpbs_pred import cpbs_pkg::*; (
  input  cfg_t              cfg_i,
  input  logic [DATA_W-1:0] element_i,
  input  logic [DATA_W-1:0] other_i,
  input  logic [DATA_W-1:0] upper_i,
  output logic              bit_o
);

  logic signed [DATA_W-1:0] xs, ys, us;
  logic lt_y, eq_y, lt_u, eq_u;
  logic cmp_bit, rng_bit, lo_excl, hi_excl, lo_ok, hi_ok;

  assign xs = sext(element_i, cfg_i.element_width);
  assign ys = sext((cfg_i.scan_kind == KIND_VALUE) ? cfg_i.scan_value : other_i,
                   cfg_i.element_width);
  assign us = sext(upper_i, cfg_i.element_width);

  // comparisons against ys, shared by all scan kinds, and against us, used by range scans only
  assign lt_y = xs < ys;
  assign eq_y = xs == ys;
  assign lt_u = xs < us;
  assign eq_u = xs == us;

  always_comb begin
    unique case (cfg_i.compare_op)
      OP_EQ:   cmp_bit = eq_y;
      OP_GE:   cmp_bit = !lt_y;
      OP_GT:   cmp_bit = !lt_y && !eq_y;
      OP_LE:   cmp_bit = lt_y || eq_y;
      OP_LT:   cmp_bit = lt_y;
      OP_NEQ:  cmp_bit = !eq_y;
      default: cmp_bit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (cfg_i.range_mode)
      RNG_INC_INC: begin lo_excl = 1'b0; hi_excl = 1'b0; end
      RNG_INC_EXC: begin lo_excl = 1'b0; hi_excl = 1'b1; end
      RNG_EXC_INC: begin lo_excl = 1'b1; hi_excl = 1'b0; end
      RNG_EXC_EXC: begin lo_excl = 1'b1; hi_excl = 1'b1; end
      default:     begin lo_excl = 1'b1; hi_excl = 1'b1; end
    endcase
  end

  // lower bound sits in ys: lower <= x is !(x < lower)
  assign lo_ok   = lo_excl ? (!lt_y && !eq_y) : !lt_y;
  assign hi_ok   = hi_excl ? lt_u : (lt_u || eq_u);
  assign rng_bit = lo_ok && hi_ok;

  always_comb begin
    unique case (cfg_i.scan_kind)
      KIND_VALUE, KIND_COLUMN: bit_o = cmp_bit;
      KIND_RANGE:              bit_o = rng_bit;
      default:                 bit_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/column_predicate_bitmap_scan_core.sv @@
`default_nettype none
// Column scan filter: one predicate bit per column element, packed into mask bytes.
// Input channel in_ch carries element, other_operand, upper_bound and end_of_scan;
// a transfer happens at a clock edge with valid and ready both high.
// Output channel out_ch carries mask_byte (bit i = i-th element of the group) and
// last_byte; a byte goes out after every BITS_PER_RESULT elements, or early with
// zero padding on the element flagged end_of_scan.
// Configuration: cfg_we_i, cfg_idx_i, cfg_wdata_i write one register per edge
// (0 scan kind, 1 element width, 2 compare op, 3 range mode, 4 scan value);
// the user must make writes only while no element is in flight; the core leaves this to the user.
// Path: the transfer loads the element into the input register; the predicate is
// evaluated there and a completed byte is loaded into the result register, from
// which the receiver takes it.
// Throughput: one element per cycle unless a completed byte is held back by an
// occupied result register; the 64-bit compare is combinational between the two.
// When the receiver stalls, the result register holds; the input register keeps
// filling groups that do not complete, and in_ch.ready drops only once a
// completed byte finds the result register still occupied.
// Reset clears the open group and both valid flags and sets the configuration registers to their defaults.

module column_predicate_bitmap_scan_core import cpbs_pkg::*; #(
  parameter int unsigned BITS_PER_RESULT = BITS_PER_RESULT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cpbs_in_if.sink              in_ch,
  cpbs_out_if.source           out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned CntW = (BITS_PER_RESULT > 1) ? $clog2(BITS_PER_RESULT) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(BITS_PER_RESULT - 1);

  cfg_t cfg_q;

  logic                s1_valid_q;
  logic [DATA_W-1:0]   s1_elem_q, s1_other_q, s1_upper_q;
  logic                s1_last_q;

  logic [BITS_PER_RESULT-1:0] pend_q, grp;
  logic [CntW-1:0]            cnt_q;

  logic              out_valid_q;
  logic [MASK_W-1:0] out_mask_q;
  logic              out_last_q;

  logic pred_bit, emit, out_free, s1_adv, in_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_kind     <= KIND_VALUE;
      cfg_q.element_width <= EW_64;
      cfg_q.compare_op    <= OP_EQ;
      cfg_q.range_mode    <= RNG_INC_INC;
      cfg_q.scan_value    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCAN_KIND:     cfg_q.scan_kind     <= cfg_wdata_i[1:0];
        CFG_ELEMENT_WIDTH: cfg_q.element_width <= cfg_wdata_i[1:0];
        CFG_COMPARE_OP:    cfg_q.compare_op    <= cfg_wdata_i[2:0];
        CFG_RANGE_MODE:    cfg_q.range_mode    <= cfg_wdata_i[1:0];
        CFG_SCAN_VALUE:    cfg_q.scan_value    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  cpbs_pred u_pred (
    .cfg_i     (cfg_q),
    .element_i (s1_elem_q),
    .other_i   (s1_other_q),
    .upper_i   (s1_upper_q),
    .bit_o     (pred_bit)
  );

  assign emit     = s1_valid_q && ((cnt_q == CntLast) || s1_last_q);
  assign out_free = !out_valid_q || out_ch.ready;
  assign s1_adv   = s1_valid_q && (!emit || out_free);
  assign in_ready = !s1_valid_q || s1_adv;

  assign in_ch.ready = in_ready;

  always_comb begin
    grp        = pend_q;
    grp[cnt_q] = pend_q[cnt_q] | pred_bit;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_ch.valid) begin
      s1_elem_q  <= in_ch.element;
      s1_other_q <= in_ch.other_operand;
      s1_upper_q <= in_ch.upper_bound;
      s1_last_q  <= in_ch.end_of_scan;
    end
  end

  // open group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else if (s1_adv) begin
      if (emit) begin
        pend_q <= '0;
        cnt_q  <= '0;
      end else begin
        pend_q <= grp;
        cnt_q  <= cnt_q + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_mask_q <= grp[MASK_W-1:0];
      out_last_q <= s1_last_q;
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.mask_byte = out_mask_q;
  assign out_ch.last_byte = out_last_q;

`ifndef SYNTH
  // a completed group always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && emit) |=> out_valid_q)
    else $error("completed group did not reach the result register");

  // the end of a scan leaves an empty group behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (cnt_q == '0) && (pend_q == '0))
    else $error("group not cleared after end of scan");

  // an element that does not complete a group moves the count forward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !emit) |=> (cnt_q != '0))
    else $error("group count wrapped without a result");

  // a completed group waiting on a full result register holds the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !out_free) |-> !in_ready)
    else $error("input taken while a completed group is blocked");
`endif

endmodule

`default_nettype wire
